// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the run-length queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define RLQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check built on the clocked form.
`define RLQ_ASSERT_IMP(label, cond, prop, msg) \
    `RLQ_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ----- rtl/core/rlq_pkg.sv -----
// Package: types, constants and helpers of the run-length queue.
`timescale 1ns / 1ps
package rlq_pkg;

    localparam int RUN_SLOTS = 1024;
    localparam int SLOT_W    = $clog2(RUN_SLOTS);
    localparam int HELD_W    = $clog2(RUN_SLOTS + 1);

    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int SUM_W = 63;
    localparam int PRD_W = VAL_W + CNT_W;

    localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

    // Opcodes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [HELD_W-1:0] held_t;

    // One stored run
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } run_entry_t;

    // Control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
        logic acc_en;
    } mac_ctrl_t;

    // Circular slot advance
    function automatic slot_t next_slot(input slot_t idx);
        slot_t res;
        if (idx == slot_t'(RUN_SLOTS - 1)) begin
            res = '0;
        end
        else begin
            res = idx + slot_t'(1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/rlq_store.sv -----
// Run store: one-port-write, one-port-read synchronous memory of runs.
`timescale 1ns / 1ps
module rlq_store (
    input  logic               clk,
    input  logic               wr_en,
    input  rlq_pkg::slot_t     wr_addr,
    input  rlq_pkg::run_entry_t wr_data,
    input  logic               rd_en,
    input  rlq_pkg::slot_t     rd_addr,
    output rlq_pkg::run_entry_t rd_data
);
    import rlq_pkg::*;

    run_entry_t mem [RUN_SLOTS];
    run_entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/rlq_mac.sv -----
// Multiply-accumulate unit: registered product, saturating 63-bit sum.
`timescale 1ns / 1ps
module rlq_mac (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rlq_pkg::mac_ctrl_t          ctrl,
    input  logic [rlq_pkg::VAL_W-1:0]   mul_a,
    input  logic [rlq_pkg::CNT_W-1:0]   mul_b,
    output logic [rlq_pkg::SUM_W-1:0]   acc,
    output logic                        sat
);
    import rlq_pkg::*;

    logic [PRD_W-1:0] product_reg;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             sat_reg, sat_next;
    logic [PRD_W:0]   sum_wide;

    // Product stage
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en) begin
            product_reg <= PRD_W'(mul_a) * PRD_W'(mul_b);
        end
    end

    // Saturating add; once clamped the sum stays put
    assign sum_wide = (PRD_W + 1)'(acc_reg) + (PRD_W + 1)'(product_reg);

    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (ctrl.clear) begin
            acc_next = '0;
            sat_next = 1'b0;
        end
        else if (ctrl.acc_en && !sat_reg) begin
            if (sum_wide > (PRD_W + 1)'(SUM_LIMIT)) begin
                acc_next = SUM_LIMIT;
                sat_next = 1'b1;
            end
            else begin
                acc_next = sum_wide[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end
        else begin
            acc_reg <= acc_next;
            sat_reg <= sat_next;
        end
    end

    assign acc = acc_reg;
    assign sat = sat_reg;

endmodule

// ----- rtl/core/run_length_fifo_sum_drain.sv -----
// Top level: run-length queue with summing drain, command interface.
//
// A command is taken when start is high and busy is low; busy stays high
// until the command is finished. Each command gives exactly one result beat,
// shown for one cycle with done high, and the receiver cannot stall it. A push
// stores its run, unless its count is zero or the store is full, and then gives
// the done beat. A take runs a memory read, multiply and accumulate step for
// every stored run it touches (through the single run store read port and the
// shared multiplier), so its latency follows the number of runs drained. The run
// store needs no clearing after reset; only entries that hold a run are ever read.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module run_length_fifo_sum_drain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [rlq_pkg::VAL_W-1:0]   run_value,
    input  logic [rlq_pkg::CNT_W-1:0]   run_count,
    input  logic [rlq_pkg::CNT_W-1:0]   take_count,
    output logic                        done,
    output logic [rlq_pkg::SUM_W-1:0]   taken_sum,
    output logic [1:0]                  status,
    output logic                        sum_saturated
);
    import rlq_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PUSH = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;

    logic [2:0]       state_reg, state_next;
    slot_t            head_reg, head_next;
    slot_t            tail_reg, tail_next;
    held_t            held_reg, held_next;
    logic             done_reg, done_next;

    logic [VAL_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] want_reg, want_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [1:0]       status_reg, status_next;
    logic             sat_reg, sat_next;

    logic             wr_en;
    slot_t            wr_addr;
    run_entry_t       wr_data;
    logic             rd_en;
    run_entry_t       rd_data;

    mac_ctrl_t        mac_ctrl;
    logic [CNT_W-1:0] mul_b;
    logic [SUM_W-1:0] mac_acc;
    logic             mac_sat;

    rlq_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    rlq_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .mul_a (rd_data.value),
        .mul_b (mul_b),
        .acc   (mac_acc),
        .sat   (mac_sat)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        done_next   = 1'b0;
        value_next  = value_reg;
        count_next  = count_reg;
        want_next   = want_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        sat_next    = sat_reg;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        wr_data     = '{value: value_reg, count: count_reg};
        rd_en       = 1'b0;
        mac_ctrl    = '0;
        mul_b       = want_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start) begin
                    mac_ctrl.clear = 1'b1;
                    value_next     = run_value;
                    count_next     = run_count;
                    want_next      = take_count;
                    state_next     = (opcode == OP_TAKE) ? S_CHK : S_PUSH;
                end
            end
            S_PUSH:
            begin
                done_next   = 1'b1;
                sum_next    = '0;
                sat_next    = 1'b0;
                status_next = ST_OK;
                if (count_reg != '0) begin
                    if (held_reg == held_t'(RUN_SLOTS)) begin
                        status_next = ST_FULL;
                    end
                    else begin
                        wr_en     = 1'b1;
                        tail_next = next_slot(tail_reg);
                        held_next = held_reg + held_t'(1);
                    end
                end
                state_next = S_IDLE;
            end
            S_CHK:
            begin
                if (want_reg == '0 || held_reg == '0) begin
                    done_next   = 1'b1;
                    sum_next    = mac_acc;
                    sat_next    = mac_sat;
                    status_next = (want_reg != '0) ? ST_SHORT : ST_OK;
                    state_next  = S_IDLE;
                end
                else begin
                    rd_en      = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // Drain the head run whole, or trim it in place
                mac_ctrl.mul_en = 1'b1;
                if (want_reg >= rd_data.count) begin
                    mul_b     = rd_data.count;
                    want_next = want_reg - rd_data.count;
                    head_next = next_slot(head_reg);
                    held_next = held_reg - held_t'(1);
                end
                else begin
                    mul_b     = want_reg;
                    wr_en     = 1'b1;
                    wr_addr   = head_reg;
                    wr_data   = '{value: rd_data.value, count: rd_data.count - want_reg};
                    want_next = '0;
                end
                state_next = S_ACC;
            end
            S_ACC:
            begin
                mac_ctrl.acc_en = 1'b1;
                state_next      = S_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            held_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            held_reg  <= held_next;
            done_reg  <= done_next;
        end
    end

    // Command and result payload
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        count_reg  <= count_next;
        want_reg   <= want_next;
        sum_reg    <= sum_next;
        status_reg <= status_next;
        sat_reg    <= sat_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign taken_sum     = sum_reg;
    assign status        = status_reg;
    assign sum_saturated = sat_reg;

    // Checks
    `RLQ_ASSERT(a_held_range, (held_reg <= held_t'(RUN_SLOTS)), "run count above capacity")
    `RLQ_ASSERT_IMP(a_short_empty, done_reg && status_reg == ST_SHORT, held_reg == '0, "short take left runs behind")
    `RLQ_ASSERT_IMP(a_full_held, done_reg && status_reg == ST_FULL, held_reg == held_t'(RUN_SLOTS), "full status with free slots")
    `RLQ_ASSERT_IMP(a_sat_clamp, done_reg && sat_reg, sum_reg == SUM_LIMIT, "saturated sum not clamped")
    `RLQ_ASSERT_IMP(a_done_src, done_reg, $past(state_reg) != S_IDLE, "result beat without a command")

endmodule
